### sv/lavm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lavm_pkg
// Shared widths, types and codes of the look-at view matrix builder.
// ============================================================================
package lavm_pkg;

    // Fixed-point format of positions, axes and matrix entries.
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;

    // Normalizer widths.
    localparam int NIN_W      = 64;
    localparam int LEN_W      = $clog2(NIN_W + 1);
    localparam int NORM_W     = 30;
    localparam int SQ_W       = 2 * NORM_W;
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_W     = 2 * ROOT_STEPS;
    localparam int DIV_W      = NORM_W + 2;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int UNIT_W     = FRAC_BITS + 2;
    localparam int NUM_W      = NORM_W + FRAC_BITS;
    localparam int NORM_LAT   = ROOT_STEPS + QUO_W + 7;

    // Cross and dot product widths.
    localparam int XP_W       = DIFF_W + UNIT_W;
    localparam int XR_W       = XP_W + 1;
    localparam int DP_W       = COORD_W + UNIT_W;
    localparam int DS_W       = DP_W + 2;
    localparam int RT_W       = DS_W + 1;

    // Stream layout.
    localparam int NUM_IN     = 9;
    localparam int IN_W       = NUM_IN * COORD_W;
    localparam int NUM_COLS   = 4;
    localparam int OUT_W      = NUM_COLS * COORD_W;
    localparam int NUM_ROWS   = 4;
    localparam int ROW_W      = 2;
    localparam logic [ROW_W-1:0] FIRST_ROW = ROW_W'(0);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(NUM_ROWS - 1);
    localparam logic [COORD_W-1:0] ONE_Q   = COORD_W'(1) << FRAC_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [NIN_W-1:0]   nin_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef nin_t  [2:0]               vin_t;
    typedef unit_t [2:0]               unit3_t;

    // Values that ride along a normalizer pipeline.
    typedef struct packed {
        coord_t [2:0] eye;
        diff_t  [2:0] fwd;
        unit_t  [2:0] xn;
        unit_t  [2:0] zn;
    } side_t;

endpackage

### sv/lavm_norm.sv
`timescale 1ns / 1ps
// ============================================================================
// lavm_norm
// Pipelined normalizer of a three component vector to unit length in
// Q.FRAC_BITS, with a side payload delayed by the same number of stages.
// ============================================================================
module lavm_norm import lavm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  vin_t   in_vec,
    input  side_t  in_side,
    output logic   out_valid,
    output unit3_t out_unit,
    output side_t  out_side
);

    typedef struct packed {
        logic [2:0][NORM_W-1:0] m;
        logic [2:0]             neg;
        logic                   zero;
    } lane_t;

    typedef struct packed {
        logic [2:0][DIV_W-1:0] rem;
        logic [2:0][QUO_W-1:0] low;
        logic [2:0][QUO_W-1:0] quo;
        logic [DIV_W-1:0]      d;
        lane_t                 ln;
    } div_t;

    logic [2:0][NIN_W-1:0] mag_reg;
    logic [2:0]            neg0_reg;
    logic [2:0][NIN_W-1:0] mag1_reg;
    logic [2:0]            neg1_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [NIN_W-1:0]      or_v;
    lane_t                 lane2_reg;
    lane_t                 lane2_next;
    logic [NIN_W-1:0]      sh;
    logic [2:0][SQ_W-1:0]  sq_reg;
    lane_t                 lane3_reg;

    logic [ROOT_W-1:0] rn_reg  [ROOT_STEPS+1];
    logic [ROOT_W-1:0] rn_next [ROOT_STEPS+1];
    logic [ROOT_W-1:0] rr_reg  [ROOT_STEPS+1];
    logic [ROOT_W-1:0] rr_next [ROOT_STEPS+1];
    lane_t             rl_reg  [ROOT_STEPS+1];
    logic [ROOT_W-1:0] bitv;
    logic [ROOT_W-1:0] trial;

    div_t               dv_reg  [QUO_W+1];
    div_t               dv_next [QUO_W+1];
    logic [NUM_W-1:0]   num;
    logic [DIV_W:0]     r2;

    unit3_t             unit_reg;
    logic [NORM_LAT-1:0] vld_reg;
    side_t              side_reg [NORM_LAT];

    // Magnitudes and signs.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg0_reg[i] <= in_vec[i][NIN_W-1];
                mag_reg[i]  <= in_vec[i][NIN_W-1] ? NIN_W'(-in_vec[i]) : NIN_W'(in_vec[i]);
            end
        end
    end

    // Bit length of the largest magnitude equals that of the OR of all three.
    always_comb begin
        or_v     = mag_reg[0] | mag_reg[1] | mag_reg[2];
        len_next = '0;
        for (int b = 0; b < NIN_W; b++) begin
            if (or_v[b]) begin
                len_next = LEN_W'(b + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg <= mag_reg;
            neg1_reg <= neg0_reg;
            len_reg  <= len_next;
        end
    end

    // Common shift that brings the largest magnitude into [2^29, 2^30).
    always_comb begin
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (len_reg > LEN_W'(NORM_W)) begin
                sh = mag1_reg[i] >> (len_reg - LEN_W'(NORM_W));
            end else begin
                sh = mag1_reg[i] << (LEN_W'(NORM_W) - len_reg);
            end
            lane2_next.m[i] = sh[NORM_W-1:0];
        end
        lane2_next.neg  = neg1_reg;
        lane2_next.zero = (len_reg == '0);
    end

    // Squares, then their sum feeds the root pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            lane2_reg <= lane2_next;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(lane2_reg.m[i]) * SQ_W'(lane2_reg.m[i]);
            end
            lane3_reg <= lane2_reg;
        end
    end

    // Floor square root, one result bit per stage.
    always_comb begin
        bitv       = '0;
        trial      = '0;
        rn_next[0] = ROOT_W'(sq_reg[0]) + ROOT_W'(sq_reg[1]) + ROOT_W'(sq_reg[2]);
        rr_next[0] = '0;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            bitv  = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            trial = rr_reg[k] + bitv;
            if (rn_reg[k] >= trial) begin
                rn_next[k+1] = rn_reg[k] - trial;
                rr_next[k+1] = (rr_reg[k] >> 1) + bitv;
            end else begin
                rn_next[k+1] = rn_reg[k];
                rr_next[k+1] = rr_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rl_reg[0] <= lane3_reg;
            for (int k = 0; k <= ROOT_STEPS; k++) begin
                rn_reg[k] <= rn_next[k];
                rr_reg[k] <= rr_next[k];
            end
            for (int k = 0; k < ROOT_STEPS; k++) begin
                rl_reg[k+1] <= rl_reg[k];
            end
        end
    end

    // Restoring division of each scaled magnitude by the length.
    always_comb begin
        num = '0;
        r2  = '0;
        dv_next[0].d  = rr_reg[ROOT_STEPS][DIV_W-1:0];
        dv_next[0].ln = rl_reg[ROOT_STEPS];
        for (int i = 0; i < 3; i++) begin
            num = {rl_reg[ROOT_STEPS].m[i], {FRAC_BITS{1'b0}}};
            dv_next[0].rem[i] = DIV_W'(num[NUM_W-1:QUO_W]);
            dv_next[0].low[i] = num[QUO_W-1:0];
            dv_next[0].quo[i] = '0;
        end
        for (int j = 0; j < QUO_W; j++) begin
            dv_next[j+1].d  = dv_reg[j].d;
            dv_next[j+1].ln = dv_reg[j].ln;
            for (int i = 0; i < 3; i++) begin
                r2 = {dv_reg[j].rem[i], dv_reg[j].low[i][QUO_W-1]};
                dv_next[j+1].low[i] = dv_reg[j].low[i] << 1;
                if (r2 >= {1'b0, dv_reg[j].d}) begin
                    dv_next[j+1].rem[i] = DIV_W'(r2 - {1'b0, dv_reg[j].d});
                    dv_next[j+1].quo[i] = {dv_reg[j].quo[i][QUO_W-2:0], 1'b1};
                end else begin
                    dv_next[j+1].rem[i] = r2[DIV_W-1:0];
                    dv_next[j+1].quo[i] = {dv_reg[j].quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= QUO_W; j++) begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    // Sign restore; a zero vector stays zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_reg[QUO_W].ln.zero) begin
                    unit_reg[i] <= '0;
                end else if (dv_reg[QUO_W].ln.neg[i]) begin
                    unit_reg[i] <= -unit_t'({1'b0, dv_reg[QUO_W].quo[i]});
                end else begin
                    unit_reg[i] <= unit_t'({1'b0, dv_reg[QUO_W].quo[i]});
                end
            end
        end
    end

    // Valid bits and side payload travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < NORM_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NORM_LAT-1];
    assign out_unit  = unit_reg;
    assign out_side  = side_reg[NORM_LAT-1];

endmodule

### sv/look_at_view_matrix_builder.sv
`timescale 1ns / 1ps
// ============================================================================
// look_at_view_matrix_builder
// Builds a left-handed look-at view matrix from eye, target and up vectors.
// ============================================================================
// Usage:
// The input stream carries one item per transfer: eye, target and up, all
// signed Q16.16. The output stream returns the 4x4 view matrix as four
// transfers, row 0 first; tuser gives the row number and tlast marks row 3.
// Rows 0 to 2 hold the side, up and forward axis components; row 3 holds the
// negated eye dot products, rounded and saturated, and 1.0 in its corner.
// The datapath is one pipeline: up and forward are normalized side by side,
// then the side axis and the new up axis are each formed and normalized,
// then the dot products are taken. Each normalizer is 56 stages (32 square
// root stages, 17 divide stages), 177 register stages in all. A new item
// may enter every cycle while the pipeline advances; the output holds each
// matrix for its four row transfers, so with a steady stream the output
// channel sets the sustained rate. When the receiver stalls, the whole
// pipeline holds and s_axis_tready is low; nothing is dropped or repeated.
// Reset clears all valid bits.
// ============================================================================
module look_at_view_matrix_builder import lavm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // col0, col1, col2, col3
    output logic [OUT_W-1:0] m_axis_tdata,
    // row_index
    output logic [ROW_W-1:0] m_axis_tuser,
    output logic             m_axis_tlast
);

    logic adv;

    logic   a_valid_reg;
    coord_t a_eye_reg [3];
    diff_t  a_fwd_reg [3];
    coord_t a_up_reg  [3];
    vin_t   up_vec, fwd_vec;
    side_t  a_side;

    logic   u_valid, f_valid;
    unit3_t un, zn;
    side_t  u_side, f_side;

    logic                   b1_valid_reg;
    logic signed [XP_W-1:0] b1_p_reg [6];
    side_t                  b1_side_reg;
    logic                   b2_valid_reg;
    logic signed [XR_W-1:0] b2_xr_reg [3];
    side_t                  b2_side_reg;
    vin_t                   xr_vec;

    logic   x_valid;
    unit3_t xn;
    side_t  x_side;

    logic                   c1_valid_reg;
    logic signed [XP_W-1:0] c1_p_reg [6];
    side_t                  c1_side_reg;
    logic                   c2_valid_reg;
    logic signed [XR_W-1:0] c2_yr_reg [3];
    side_t                  c2_side_reg;
    vin_t                   yr_vec;

    logic   y_valid;
    unit3_t yn;
    side_t  y_side;

    logic                   d1_valid_reg;
    logic signed [DP_W-1:0] d1_p_reg [3][3];
    unit3_t                 d1_xn_reg, d1_yn_reg, d1_zn_reg;
    logic                   d2_valid_reg;
    logic signed [DS_W-1:0] d2_s_reg [3];
    unit3_t                 d2_xn_reg, d2_yn_reg, d2_zn_reg;
    logic                   d3_valid_reg;
    coord_t                 d3_dot_reg [3];
    coord_t                 dot_next [3];
    unit3_t                 d3_xn_reg, d3_yn_reg, d3_zn_reg;
    logic signed [RT_W-1:0] t_v, r_v;

    logic             out_valid_reg;
    logic [ROW_W-1:0] row_reg;
    coord_t           o_dot_reg [3];
    unit_t            o_xn_reg [3];
    unit_t            o_yn_reg [3];
    unit_t            o_zn_reg [3];

    // The pipeline advances unless the output still owes rows.
    assign adv           = !out_valid_reg || (m_axis_tready && (row_reg == LAST_ROW));
    assign s_axis_tready = adv;

    // Input stage: unpack and form the forward vector.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a_eye_reg[i] <= s_axis_tdata[i*COORD_W +: COORD_W];
                a_up_reg[i]  <= s_axis_tdata[(6+i)*COORD_W +: COORD_W];
                a_fwd_reg[i] <= DIFF_W'($signed(s_axis_tdata[(3+i)*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(s_axis_tdata[i*COORD_W +: COORD_W]));
            end
        end
    end

    always_comb begin
        a_side = '0;
        for (int i = 0; i < 3; i++) begin
            up_vec[i]     = NIN_W'(a_up_reg[i]);
            fwd_vec[i]    = NIN_W'(a_fwd_reg[i]);
            a_side.eye[i] = a_eye_reg[i];
            a_side.fwd[i] = a_fwd_reg[i];
        end
    end

    lavm_norm u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_vec    (up_vec),
        .in_side   (a_side),
        .out_valid (u_valid),
        .out_unit  (un),
        .out_side  (u_side)
    );

    lavm_norm u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_vec    (fwd_vec),
        .in_side   (a_side),
        .out_valid (f_valid),
        .out_unit  (zn),
        .out_side  (f_side)
    );

    // Side axis: forward cross unit up, products then differences.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= u_valid && f_valid;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_p_reg[0] <= $signed(u_side.fwd[1]) * $signed(un[2]);
            b1_p_reg[1] <= $signed(u_side.fwd[2]) * $signed(un[1]);
            b1_p_reg[2] <= $signed(u_side.fwd[2]) * $signed(un[0]);
            b1_p_reg[3] <= $signed(u_side.fwd[0]) * $signed(un[2]);
            b1_p_reg[4] <= $signed(u_side.fwd[0]) * $signed(un[1]);
            b1_p_reg[5] <= $signed(u_side.fwd[1]) * $signed(un[0]);
            b1_side_reg.eye <= f_side.eye;
            b1_side_reg.fwd <= u_side.fwd;
            b1_side_reg.xn  <= '0;
            b1_side_reg.zn  <= zn;
            for (int i = 0; i < 3; i++) begin
                b2_xr_reg[i] <= XR_W'(b1_p_reg[2*i]) - XR_W'(b1_p_reg[2*i+1]);
            end
            b2_side_reg <= b1_side_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xr_vec[i] = NIN_W'(b2_xr_reg[i]);
        end
    end

    lavm_norm u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (b2_valid_reg),
        .in_vec    (xr_vec),
        .in_side   (b2_side_reg),
        .out_valid (x_valid),
        .out_unit  (xn),
        .out_side  (x_side)
    );

    // New up axis: unit side cross forward.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end else if (adv) begin
            c1_valid_reg <= x_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_p_reg[0] <= $signed(xn[1]) * $signed(x_side.fwd[2]);
            c1_p_reg[1] <= $signed(xn[2]) * $signed(x_side.fwd[1]);
            c1_p_reg[2] <= $signed(xn[2]) * $signed(x_side.fwd[0]);
            c1_p_reg[3] <= $signed(xn[0]) * $signed(x_side.fwd[2]);
            c1_p_reg[4] <= $signed(xn[0]) * $signed(x_side.fwd[1]);
            c1_p_reg[5] <= $signed(xn[1]) * $signed(x_side.fwd[0]);
            c1_side_reg.eye <= x_side.eye;
            c1_side_reg.fwd <= x_side.fwd;
            c1_side_reg.xn  <= xn;
            c1_side_reg.zn  <= x_side.zn;
            for (int i = 0; i < 3; i++) begin
                c2_yr_reg[i] <= XR_W'(c1_p_reg[2*i]) - XR_W'(c1_p_reg[2*i+1]);
            end
            c2_side_reg <= c1_side_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            yr_vec[i] = NIN_W'(c2_yr_reg[i]);
        end
    end

    lavm_norm u_norm_upax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (c2_valid_reg),
        .in_vec    (yr_vec),
        .in_side   (c2_side_reg),
        .out_valid (y_valid),
        .out_unit  (yn),
        .out_side  (y_side)
    );

    // Eye dot products: products, sums, then negate, round and saturate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
        end else if (adv) begin
            d1_valid_reg <= y_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
        end
    end

    always_comb begin
        t_v = '0;
        r_v = '0;
        for (int a = 0; a < 3; a++) begin
            t_v = -RT_W'(d2_s_reg[a]) + (RT_W'(1) << (FRAC_BITS - 1));
            r_v = t_v >>> FRAC_BITS;
            if ((&r_v[RT_W-1:COORD_W-1]) || !(|r_v[RT_W-1:COORD_W-1])) begin
                dot_next[a] = r_v[COORD_W-1:0];
            end else if (r_v[RT_W-1]) begin
                dot_next[a] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                dot_next[a] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d1_p_reg[0][i] <= $signed(y_side.eye[i]) * $signed(y_side.xn[i]);
                d1_p_reg[1][i] <= $signed(y_side.eye[i]) * $signed(yn[i]);
                d1_p_reg[2][i] <= $signed(y_side.eye[i]) * $signed(y_side.zn[i]);
            end
            d1_xn_reg <= y_side.xn;
            d1_yn_reg <= yn;
            d1_zn_reg <= y_side.zn;
            for (int a = 0; a < 3; a++) begin
                d2_s_reg[a] <= DS_W'(d1_p_reg[a][0]) + DS_W'(d1_p_reg[a][1])
                             + DS_W'(d1_p_reg[a][2]);
            end
            d2_xn_reg <= d1_xn_reg;
            d2_yn_reg <= d1_yn_reg;
            d2_zn_reg <= d1_zn_reg;
            d3_dot_reg <= dot_next;
            d3_xn_reg  <= d2_xn_reg;
            d3_yn_reg  <= d2_yn_reg;
            d3_zn_reg  <= d2_zn_reg;
        end
    end

    // Output register: holds one matrix and steps through its rows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            row_reg       <= FIRST_ROW;
        end else if (adv) begin
            out_valid_reg <= d3_valid_reg;
            row_reg       <= FIRST_ROW;
        end else if (m_axis_tready) begin
            row_reg <= row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_dot_reg <= d3_dot_reg;
            for (int i = 0; i < 3; i++) begin
                o_xn_reg[i] <= d3_xn_reg[i];
                o_yn_reg[i] <= d3_yn_reg[i];
                o_zn_reg[i] <= d3_zn_reg[i];
            end
        end
    end

    // Row select for the current transfer.
    always_comb begin
        if (row_reg == LAST_ROW) begin
            m_axis_tdata = {ONE_Q, o_dot_reg[2], o_dot_reg[1], o_dot_reg[0]};
        end else begin
            m_axis_tdata = {COORD_W'(0),
                            COORD_W'(o_zn_reg[row_reg]),
                            COORD_W'(o_yn_reg[row_reg]),
                            COORD_W'(o_xn_reg[row_reg])};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = row_reg;
    assign m_axis_tlast  = (row_reg == LAST_ROW);

`ifndef SYNTHESIS
    // The input side is held while the output still owes rows of a matrix.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !(m_axis_tready && m_axis_tlast)) |-> !s_axis_tready)
        else $error("input accepted while a matrix is still being sent");

    // Rows of one matrix go out in order without gaps in numbering.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + ROW_W'(1))))
        else $error("row sequence broken");

    // A newly loaded matrix starts at row zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && d3_valid_reg) |=> (m_axis_tvalid && (m_axis_tuser == FIRST_ROW)))
        else $error("new matrix does not start at row zero");

    // The last row ends in exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tdata[OUT_W-1 -: COORD_W] == ONE_Q))
        else $error("corner entry is not one");

    // The two first normalizers run in lockstep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        u_valid == f_valid)
        else $error("normalizer valid bits disagree");
`endif

endmodule

### sim/look_at_view_matrix_builder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// look_at_view_matrix_builder_tb
// Self-checking regression of the look-at view matrix builder.
// ============================================================================
// A short directed table covers the degenerate camera setups and the
// extremes of the coordinates. A random run follows. Every accepted camera
// that is not marked coincident is run through a fixed-point predictor, and
// its four matrix rows are queued; a coincident one queues the known matrix.
// Each returned row is compared field by field with the oldest queued row.
// Both stream sides idle at random, with some stretches that have no idling.
// ============================================================================
module look_at_view_matrix_builder_tb;
    import lavm_pkg::*;

    localparam int  N_RANDOM = 200;
    localparam int  DRAIN    = 400;
    localparam longint LIMIT = 600000;

    typedef longint vec3_t [3];

    typedef struct {
        logic [ROW_W-1:0] row;
        coord_t           col [4];
        logic             last;
    } mrow_t;

    typedef struct {
        coord_t cam [9];
        bit     coincident;
    } cam_case_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // col0, col1, col2, col3
    logic [OUT_W-1:0] m_axis_tdata;
    // row_index
    logic [ROW_W-1:0] m_axis_tuser;
    logic             m_axis_tlast;

    mrow_t  pending_rows [$];
    int     mismatches = 0;
    longint cycles = 0;
    bit     calm = 1'b0;

    look_at_view_matrix_builder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // Floor square root of a 64-bit value.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length; a zero vector stays zero.
    function automatic vec3_t unit_vec(input vec3_t v);
        longint unsigned m [3];
        longint unsigned mx, sq, l;
        vec3_t o;
        int len;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return o;
        end
        len = 0;
        while (len < 64 && (mx >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > NORM_W) m[i] = m[i] >> (len - NORM_W);
            else if (len < NORM_W) m[i] = m[i] << (NORM_W - len);
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        l  = floor_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = longint'((m[i] << FRAC_BITS) / l);
            o[i] = (v[i] < 0) ? -q : q;
        end
        return o;
    endfunction

    function automatic vec3_t cross_vec(input vec3_t a, input vec3_t b);
        vec3_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    // Negated dot product, rounded half up to the fixed-point grid, saturated.
    function automatic coord_t eye_offset(input vec3_t e, input vec3_t a);
        longint s, t, r;
        s = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
        t = -s + (longint'(1) << (FRAC_BITS - 1));
        r = t >>> FRAC_BITS;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return coord_t'(r);
    endfunction

    // Queue the four rows of the view matrix for one camera.
    function automatic void predict_view(input coord_t cam [9]);
        vec3_t eye, fwd, up, un, xn, yn, zn;
        mrow_t r;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(cam[i]);
            fwd[i] = longint'(cam[3 + i]) - eye[i];
            up[i]  = longint'(cam[6 + i]);
        end
        un = unit_vec(up);
        xn = unit_vec(cross_vec(fwd, un));
        yn = unit_vec(cross_vec(xn, fwd));
        zn = unit_vec(fwd);
        for (int k = 0; k < 3; k++) begin
            r.row    = ROW_W'(k);
            r.col[0] = coord_t'(xn[k]);
            r.col[1] = coord_t'(yn[k]);
            r.col[2] = coord_t'(zn[k]);
            r.col[3] = '0;
            r.last   = 1'b0;
            pending_rows.push_back(r);
        end
        r.row    = LAST_ROW;
        r.col[0] = eye_offset(eye, xn);
        r.col[1] = eye_offset(eye, yn);
        r.col[2] = eye_offset(eye, zn);
        r.col[3] = ONE_Q;
        r.last   = 1'b1;
        pending_rows.push_back(r);
    endfunction

    // Eye on the target: the axes vanish and the matrix is known by sight.
    function automatic void queue_coincident();
        mrow_t r;
        for (int k = 0; k < NUM_ROWS; k++) begin
            r.row  = ROW_W'(k);
            r.col  = '{0, 0, 0, 0};
            r.last = (k == NUM_ROWS - 1);
            if (k == NUM_ROWS - 1) r.col[3] = ONE_Q;
            pending_rows.push_back(r);
        end
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
            default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("look_at_view_matrix_builder regression: fail");
            $finish;
        end
    end

    // Result side: compare each row transfer, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row %0d", m_axis_tuser);
            end else begin
                mrow_t e;
                bit bad;
                e   = pending_rows.pop_front();
                bad = (m_axis_tuser != e.row) || (m_axis_tlast != e.last);
                for (int c = 0; c < NUM_COLS; c++)
                    if (m_axis_tdata[c*COORD_W +: COORD_W] != e.col[c]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp row %0d %h %h %h %h last %b, got row %0d %h last %b",
                                 e.row, e.col[0], e.col[1], e.col[2], e.col[3], e.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
        if (aresetn) m_axis_tready <= calm ? 1'b1 : (gap_len() == 0);
    end

    // Camera side.
    initial begin
        cam_case_t cases [$];
        cam_case_t cc;
        int n_total;
        int mode;
        localparam coord_t MAXC = 32'sh7FFF_FFFF;
        localparam coord_t MINC = 32'sh8000_0000;
        localparam coord_t ONE  = 32'sh0001_0000;

        // Directed table.
        cc.coincident = 1'b1;
        cc.cam = '{0, 0, 0, 0, 0, 0, 0, ONE, 0};                  cases.push_back(cc);
        cc.cam = '{MAXC, MINC, MAXC, MAXC, MINC, MAXC, 0, ONE, 0};  cases.push_back(cc);
        cc.cam = '{MINC, MINC, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC}; cases.push_back(cc);
        cc.coincident = 1'b0;
        cc.cam = '{0, 0, 0, 0, 0, ONE, 0, ONE, 0};                  cases.push_back(cc);
        cc.cam = '{0, 0, 0, 0, 0, ONE, 0, 0, 0};                    cases.push_back(cc);
        cc.cam = '{0, 0, 0, 0, 0, ONE, 0, 0, 32'sh0005_0000};       cases.push_back(cc);
        cc.cam = '{0, 0, 0, 0, 0, ONE, 0, 0, -32'sh0003_0000};      cases.push_back(cc);
        cc.cam = '{MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, ONE, 0};  cases.push_back(cc);
        cc.cam = '{MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC}; cases.push_back(cc);
        cc.cam = '{MAXC, 0, 0, MINC, ONE, 0, MAXC, MAXC, MINC};     cases.push_back(cc);
        cc.cam = '{MAXC, MAXC, MAXC, 0, 0, 0, 1, 0, 0};             cases.push_back(cc);
        cc.cam = '{-32'sh0005_0000, 32'sh0002_0000, 32'sh0001_8000,
                   0, 0, 0, 0, ONE, 0};                             cases.push_back(cc);
        cc.cam = '{1, 1, 1, 2, 2, 2, -1, 1, -1};                   cases.push_back(cc);
        cc.cam = '{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                   32'hFFFF_0000, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'hFFFF_FFFF};                                  cases.push_back(cc);

        // Random cameras: mostly moderate scenes, some full-range noise,
        // some degenerate setups.
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 2);
            cc.coincident = 1'b0;
            for (int i = 0; i < 9; i++) cc.cam[i] = rand_coord(mode);
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) cc.cam[3 + i] = cc.cam[i];
                1: for (int i = 0; i < 3; i++) cc.cam[6 + i] = '0;
                2: for (int i = 0; i < 3; i++) cc.cam[6 + i] = cc.cam[3 + i] - cc.cam[i];
                default: ;
            endcase
            cases.push_back(cc);
        end
        n_total = cases.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < n_total; n++) begin
            int gap;
            calm = ((n / 40) % 3 == 2);
            if (n == n_total / 2) begin
                // Hold off until the pipeline has handed back everything.
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_rows.size() != 0) @(posedge aclk);
            end
            gap = gap_len();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            for (int i = 0; i < 9; i++) s_axis_tdata[i*COORD_W +: COORD_W] <= cases[n].cam[i];
            s_axis_tvalid <= 1'b1;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            if (cases[n].coincident) queue_coincident();
            else predict_view(cases[n].cam);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && pending_rows.size() == 0) begin
            $display("look_at_view_matrix_builder regression: pass");
        end else begin
            $display("look_at_view_matrix_builder regression: fail");
        end
        $finish;
    end

endmodule
